@@ hdl/sector_cache_tag_policy_core_macros.svh @@
// assertion macros for the sector cache tag and replacement core
`ifndef SECTOR_CACHE_TAG_POLICY_CORE_MACROS_SVH
`define SECTOR_CACHE_TAG_POLICY_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define SCTP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define SCTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sctp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sctp_pkg;

    // cache geometry
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int LBA_W   = 32;
    localparam int SLOT_W  = 6;

    // request kinds
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FILL  = 2'd2
    } req_kind_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

@@ hdl/sctp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sctp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/sector_cache_tag_policy_core.sv @@
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+---------------------------------------------
// request  | req_valid | req_stall | req_type, lba, fill_ok, last_in_request
// response | rsp_valid | rsp_stall | hit, slot, fetch_needed, fill_applied,
//          |           |           | stray_fill, last_of_request
//
// read or write request: one tag per cycle is compared through the tag ram read port;
// a hit stops the scan at the lowest matching slot, a miss scans all ENTRIES slots;
// fill report and unused request kinds skip the scan and go straight to the response state
// rst_n clears valid bits, hand and pending miss at once; the tag ram is not cleared
// req_stall is high from acceptance until the response enters the output register;
// a held response on rsp_stall does not block the next request
`timescale 1ns / 1ps
`default_nettype none
`include "sector_cache_tag_policy_core_macros.svh"

module sector_cache_tag_policy_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire logic [1:0]                   req_type,
    input  wire logic [sctp_pkg::LBA_W-1:0]   lba,
    input  wire logic                         fill_ok,
    input  wire logic                         last_in_request,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output logic                              hit,
    output logic      [sctp_pkg::SLOT_W-1:0]  slot,
    output logic                              fetch_needed,
    output logic                              fill_applied,
    output logic                              stray_fill,
    output logic                              last_of_request
);

    localparam logic [sctp_pkg::IDX_W-1:0] LAST_IDX = sctp_pkg::IDX_W'(sctp_pkg::ENTRIES - 1);

    sctp_pkg::state_t state_reg, state_next;

    // request context
    logic [sctp_pkg::LBA_W-1:0] addr_reg, addr_next;
    logic                       is_read_reg, is_read_next;

    // scan pipeline: issue stage reads the ram, compare stage checks the tag
    logic [sctp_pkg::IDX_W-1:0] issue_idx_reg, issue_idx_next;
    logic                       issue_done_reg, issue_done_next;
    logic                       cmp_busy_reg, cmp_busy_next;
    logic [sctp_pkg::IDX_W-1:0] cmp_idx_reg, cmp_idx_next;

    // cache state
    logic [sctp_pkg::ENTRIES-1:0] valid_reg, valid_next;
    logic [sctp_pkg::IDX_W-1:0]   hand_reg, hand_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [sctp_pkg::IDX_W-1:0]   pend_slot_reg, pend_slot_next;
    logic [sctp_pkg::LBA_W-1:0]   pend_addr_reg, pend_addr_next;

    // finished result waiting for the output register
    logic                        res_hit_reg, res_hit_next;
    logic [sctp_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic                        res_fetch_reg, res_fetch_next;
    logic                        res_applied_reg, res_applied_next;
    logic                        res_stray_reg, res_stray_next;
    logic                        res_last_reg, res_last_next;

    // output register
    logic                        rsp_valid_reg, rsp_valid_next;
    logic                        hit_reg, hit_next;
    logic [sctp_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic                        fetch_reg, fetch_next;
    logic                        applied_reg, applied_next;
    logic                        stray_reg, stray_next;
    logic                        last_out_reg, last_out_next;

    // tag ram port signals
    logic                       ram_we;
    logic [sctp_pkg::IDX_W-1:0] ram_waddr;
    logic [sctp_pkg::LBA_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [sctp_pkg::LBA_W-1:0] ram_rdata;

    logic                       req_accept;
    logic                       out_free;
    logic                       cmp_match;
    logic                       cmp_end;
    logic [sctp_pkg::IDX_W-1:0] victim;

    sctp_ram #(
        .WIDTH (sctp_pkg::LBA_W),
        .DEPTH (sctp_pkg::ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_idx_reg),
        .rdata (ram_rdata)
    );

    // handshake and compare terms
    assign req_stall  = (state_reg != sctp_pkg::ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign cmp_match  = cmp_busy_reg && valid_reg[cmp_idx_reg] && (ram_rdata == addr_reg);
    assign cmp_end    = cmp_busy_reg && (cmp_idx_reg == LAST_IDX);
    assign victim     = (hand_reg == LAST_IDX) ? '0 : hand_reg + sctp_pkg::IDX_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sctp_pkg::ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (req_type == sctp_pkg::REQ_READ || req_type == sctp_pkg::REQ_WRITE)
                    begin
                        state_next = sctp_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = sctp_pkg::ST_RESP;
                    end
                end
            end
            sctp_pkg::ST_SCAN:
            begin
                if (cmp_match || cmp_end)
                begin
                    state_next = sctp_pkg::ST_RESP;
                end
            end
            sctp_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = sctp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sctp_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        addr_next        = addr_reg;
        is_read_next     = is_read_reg;
        issue_idx_next   = issue_idx_reg;
        issue_done_next  = issue_done_reg;
        cmp_busy_next    = cmp_busy_reg;
        cmp_idx_next     = cmp_idx_reg;
        valid_next       = valid_reg;
        hand_next        = hand_reg;
        pend_valid_next  = pend_valid_reg;
        pend_slot_next   = pend_slot_reg;
        pend_addr_next   = pend_addr_reg;
        res_hit_next     = res_hit_reg;
        res_slot_next    = res_slot_reg;
        res_fetch_next   = res_fetch_reg;
        res_applied_next = res_applied_reg;
        res_stray_next   = res_stray_reg;
        res_last_next    = res_last_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        hit_next         = hit_reg;
        slot_next        = slot_reg;
        fetch_next       = fetch_reg;
        applied_next     = applied_reg;
        stray_next       = stray_reg;
        last_out_next    = last_out_reg;
        ram_we           = 1'b0;
        ram_waddr        = victim;
        ram_wdata        = addr_reg;
        ram_re           = 1'b0;

        unique case (state_reg)
            sctp_pkg::ST_IDLE:
            begin
                if (req_accept)
                begin
                    addr_next        = lba;
                    is_read_next     = (req_type == sctp_pkg::REQ_READ);
                    issue_idx_next   = '0;
                    issue_done_next  = 1'b0;
                    cmp_busy_next    = 1'b0;
                    res_hit_next     = 1'b0;
                    res_slot_next    = '0;
                    res_fetch_next   = 1'b0;
                    res_applied_next = 1'b0;
                    res_stray_next   = 1'b0;
                    res_last_next    = last_in_request;
                    unique case (req_type) inside
                        sctp_pkg::REQ_READ, sctp_pkg::REQ_WRITE:
                        begin
                            // tag scan follows
                        end
                        sctp_pkg::REQ_FILL:
                        begin
                            // fill report settles the pending read miss, or is flagged stray if none is pending
                            if (pend_valid_reg)
                            begin
                                res_slot_next   = sctp_pkg::SLOT_W'(pend_slot_reg);
                                pend_valid_next = 1'b0;
                                if (fill_ok)
                                begin
                                    ram_we                    = 1'b1;
                                    ram_waddr                 = pend_slot_reg;
                                    ram_wdata                 = pend_addr_reg;
                                    valid_next[pend_slot_reg] = 1'b1;
                                    res_applied_next          = 1'b1;
                                end
                            end
                            else
                            begin
                                res_stray_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused kind: no cache state change
                        end
                    endcase
                end
            end
            sctp_pkg::ST_SCAN:
            begin
                // issue stage
                if (!issue_done_reg)
                begin
                    ram_re         = 1'b1;
                    cmp_busy_next  = 1'b1;
                    cmp_idx_next   = issue_idx_reg;
                    issue_idx_next = issue_idx_reg + sctp_pkg::IDX_W'(1);
                    if (issue_idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                else
                begin
                    cmp_busy_next = 1'b0;
                end

                // compare stage: lowest matching slot ends the scan
                if (cmp_match)
                begin
                    res_hit_next  = 1'b1;
                    res_slot_next = sctp_pkg::SLOT_W'(cmp_idx_reg);
                    cmp_busy_next = 1'b0;
                end
                else if (cmp_end)
                begin
                    // miss: advance the hand to the victim
                    hand_next     = victim;
                    res_slot_next = sctp_pkg::SLOT_W'(victim);
                    cmp_busy_next = 1'b0;
                    if (is_read_reg)
                    begin
                        res_fetch_next  = 1'b1;
                        pend_valid_next = 1'b1;
                        pend_slot_next  = victim;
                        pend_addr_next  = addr_reg;
                    end
                    else
                    begin
                        ram_we             = 1'b1;
                        ram_waddr          = victim;
                        ram_wdata          = addr_reg;
                        valid_next[victim] = 1'b1;
                    end
                end
            end
            sctp_pkg::ST_RESP:
            begin
                // move the result into the output register
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    hit_next       = res_hit_reg;
                    slot_next      = res_slot_reg;
                    fetch_next     = res_fetch_reg;
                    applied_next   = res_applied_reg;
                    stray_next     = res_stray_reg;
                    last_out_next  = res_last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sctp_pkg::ST_IDLE;
            issue_done_reg <= 1'b0;
            cmp_busy_reg   <= 1'b0;
            valid_reg      <= '0;
            hand_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_slot_reg  <= '0;
            pend_addr_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            cmp_busy_reg   <= cmp_busy_next;
            valid_reg      <= valid_next;
            hand_reg       <= hand_next;
            pend_valid_reg <= pend_valid_next;
            pend_slot_reg  <= pend_slot_next;
            pend_addr_reg  <= pend_addr_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg        <= addr_next;
        is_read_reg     <= is_read_next;
        issue_idx_reg   <= issue_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        res_hit_reg     <= res_hit_next;
        res_slot_reg    <= res_slot_next;
        res_fetch_reg   <= res_fetch_next;
        res_applied_reg <= res_applied_next;
        res_stray_reg   <= res_stray_next;
        res_last_reg    <= res_last_next;
        hit_reg         <= hit_next;
        slot_reg        <= slot_next;
        fetch_reg       <= fetch_next;
        applied_reg     <= applied_next;
        stray_reg       <= stray_next;
        last_out_reg    <= last_out_next;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign hit             = hit_reg;
    assign slot            = slot_reg;
    assign fetch_needed    = fetch_reg;
    assign fill_applied    = applied_reg;
    assign stray_fill      = stray_reg;
    assign last_of_request = last_out_reg;

    // checks
    `SCTP_ASSERT_SAME(a_fill_flags_alone, clk, rst_n,
        rsp_valid && (fill_applied || stray_fill), !hit && !fetch_needed,
        "fill response carries lookup flags")
    `SCTP_ASSERT_SAME(a_stray_slot_zero, clk, rst_n,
        rsp_valid && stray_fill, slot == '0 && !fill_applied,
        "stray fill with nonzero slot")
    `SCTP_ASSERT_SAME(a_cmp_in_scan, clk, rst_n,
        cmp_busy_reg, state_reg == sctp_pkg::ST_SCAN,
        "tag compare active outside scan")
    `SCTP_ASSERT_NEXT(a_fetch_pending, clk, rst_n,
        state_reg == sctp_pkg::ST_RESP && out_free && res_fetch_reg, pend_valid_reg,
        "read miss left no pending fill")

endmodule

`default_nettype wire

@@ tb/sector_cache_tag_policy_core_tb.sv @@
`timescale 1ns / 1ps

module sector_cache_tag_policy_core_tb;

    import sctp_pkg::*;

    localparam real CLK_PERIOD   = 2.0;
    localparam int  RESET_CYCLES = 10;
    localparam int  NUM_DIR      = 25;
    localparam int  RAND_ITEMS   = 830;
    localparam int  POOL_SIZE    = 96;
    localparam int  DRAIN_CYCLES = ENTRIES + 16;
    localparam int  MAX_CYCLES   = 400000;
    localparam int  MAX_PRINTS   = 40;

    // request kind the block does not define
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              fetch;
        logic              applied;
        logic              stray;
        logic              last;
    } slot_rsp_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [LBA_W-1:0] addr;
        logic             ok;
        logic             last;
        logic             typed;
        slot_rsp_t        exp;
    } dir_row_t;

    localparam slot_rsp_t NO_EXP = '0;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    logic [1:0]        req_type = REQ_READ;
    logic [LBA_W-1:0]  lba = '0;
    logic              fill_ok = 1'b0;
    logic              last_in_request = 1'b0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              fetch_needed;
    logic              fill_applied;
    logic              stray_fill;
    logic              last_of_request;

    sector_cache_tag_policy_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req_type        (req_type),
        .lba             (lba),
        .fill_ok         (fill_ok),
        .last_in_request (last_in_request),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .hit             (hit),
        .slot            (slot),
        .fetch_needed    (fetch_needed),
        .fill_applied    (fill_applied),
        .stray_fill      (stray_fill),
        .last_of_request (last_of_request)
    );

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    // shadow copy of tags, valid bits, hand and pending read miss
    logic [LBA_W-1:0] shadow_tag [ENTRIES];
    bit               shadow_vld [ENTRIES];
    int               shadow_hand;
    bit               miss_pending;
    int               miss_slot;
    logic [LBA_W-1:0] miss_addr;

    slot_rsp_t        slot_result_q [$];
    logic [LBA_W-1:0] addr_pool [POOL_SIZE];

    // request held on the bus and its typed-in expectation, if any
    logic      cur_typed = 1'b0;
    slot_rsp_t cur_exp = '0;

    int req_accepts = 0;
    int rsp_count = 0;
    int err_count = 0;
    int cycle_count = 0;
    int n_hits = 0;
    int n_fetches = 0;
    int n_write_miss = 0;
    int n_applied = 0;
    int n_dropped = 0;
    int n_stray = 0;
    int n_unused = 0;

    function automatic slot_rsp_t predict_tag_result(input logic [1:0] kind,
                                                     input logic [LBA_W-1:0] addr,
                                                     input logic ok,
                                                     input logic last);
        slot_rsp_t r;
        int        found;
        r      = '0;
        r.last = last;
        found  = -1;
        if (kind == REQ_READ || kind == REQ_WRITE) begin
            // lowest valid matching slot wins
            for (int i = 0; i < ENTRIES; i++)
                if (found < 0 && shadow_vld[i] && shadow_tag[i] == addr)
                    found = i;
            if (found >= 0) begin
                r.hit  = 1'b1;
                r.slot = found[SLOT_W-1:0];
            end
            else begin
                shadow_hand = (shadow_hand + 1) % ENTRIES;
                r.slot      = shadow_hand[SLOT_W-1:0];
                if (kind == REQ_READ) begin
                    r.fetch      = 1'b1;
                    miss_pending = 1'b1;
                    miss_slot    = shadow_hand;
                    miss_addr    = addr;
                end
                else begin
                    // write-through retags the victim at once
                    shadow_tag[shadow_hand] = addr;
                    shadow_vld[shadow_hand] = 1'b1;
                end
            end
        end
        else if (kind == REQ_FILL) begin
            if (miss_pending) begin
                r.slot = miss_slot[SLOT_W-1:0];
                if (ok) begin
                    shadow_tag[miss_slot] = miss_addr;
                    shadow_vld[miss_slot] = 1'b1;
                    r.applied             = 1'b1;
                end
                miss_pending = 1'b0;
            end
            else
                r.stray = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [LBA_W-1:0] got,
                                   input logic [LBA_W-1:0] want);
        if (err_count < MAX_PRINTS)
            $display("%0t mismatch on %s: got %0h, expected %0h (response %0d)",
                     $realtime, what, got, want, rsp_count);
        err_count++;
    endtask

    // response check first, then capture of an accepted request
    always @(posedge clk) begin
        slot_rsp_t want;
        slot_rsp_t pred;
        if (rst_n) begin
            if (rsp_valid && !rsp_stall) begin
                if (slot_result_q.size() == 0)
                    report_mismatch("unexpected response", {hit, slot}, '0);
                else begin
                    want = slot_result_q.pop_front();
                    if (hit !== want.hit)
                        report_mismatch("hit", hit, want.hit);
                    if (slot !== want.slot)
                        report_mismatch("slot", slot, want.slot);
                    if (fetch_needed !== want.fetch)
                        report_mismatch("fetch_needed", fetch_needed, want.fetch);
                    if (fill_applied !== want.applied)
                        report_mismatch("fill_applied", fill_applied, want.applied);
                    if (stray_fill !== want.stray)
                        report_mismatch("stray_fill", stray_fill, want.stray);
                    if (last_of_request !== want.last)
                        report_mismatch("last_of_request", last_of_request, want.last);
                end
                rsp_count++;
            end
            if (req_valid && !req_stall) begin
                pred = predict_tag_result(req_type, lba, fill_ok, last_in_request);
                slot_result_q.push_back(cur_typed ? cur_exp : pred);
                n_hits       += pred.hit;
                n_fetches    += pred.fetch;
                n_applied    += pred.applied;
                n_stray      += pred.stray;
                n_write_miss += (req_type == REQ_WRITE && !pred.hit);
                n_dropped    += (req_type == REQ_FILL && !pred.stray && !pred.applied);
                n_unused     += (req_type == REQ_UNUSED);
                req_accepts++;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, slot_result_q.size());
            $display("** sector_cache_tag_policy_core: FAILED **");
            $finish;
        end
    end

    // response side stalls in stretches of differing patterns
    initial begin
        int stretch;
        int mode;
        forever begin
            stretch = $urandom_range(40, 300);
            mode    = $urandom_range(0, 3);
            repeat (stretch) begin
                @(negedge clk);
                case (mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    2: rsp_stall <= ($urandom_range(0, 9) < 7);
                    default: rsp_stall <= ((cycle_count % 24) < 14);
                endcase
            end
        end
    end

    // present one request and hold it until taken; called at a falling edge
    task automatic send_req(input logic [1:0] kind, input logic [LBA_W-1:0] addr,
                            input logic ok, input logic last,
                            input logic typed, input slot_rsp_t exp);
        int seen;
        seen = req_accepts;
        req_valid       <= 1'b1;
        req_type        <= kind;
        lba             <= addr;
        fill_ok         <= ok;
        last_in_request <= last;
        cur_typed       <= typed;
        cur_exp         <= exp;
        do
            @(negedge clk);
        while (req_accepts == seen);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            req_valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // hold off until every outstanding response is back
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (slot_result_q.size() != 0);
    endtask

    initial begin
        dir_row_t         dir_tab [NUM_DIR];
        int               burst_left;
        int               pick;
        logic [1:0]       kind;
        logic [LBA_W-1:0] addr;
        logic             ok;

        // directed sequence: stray fill, unused kind, miss/fill/hit, pending
        // replaced, failed fill, duplicate tags after write, all-ones address
        dir_tab = '{
            '{REQ_FILL,   32'h0000_0000, 1'b1, 1'b1, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 1'b1, 1'b1}},
            '{REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
            '{REQ_READ,   32'h0000_0000, 1'b0, 1'b0, 1'b1, '{1'b0, 6'd1, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{REQ_FILL,   32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, '{1'b0, 6'd1, 1'b0, 1'b1, 1'b0, 1'b1}},
            '{REQ_READ,   32'h0000_0000, 1'b1, 1'b1, 1'b1, '{1'b1, 6'd1, 1'b0, 1'b0, 1'b0, 1'b1}},
            '{REQ_WRITE,  32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, NO_EXP},
            '{REQ_READ,   32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, NO_EXP},
            '{REQ_READ,   32'h1234_5678, 1'b0, 1'b0, 1'b0, NO_EXP},
            '{REQ_READ,   32'hAAAA_5555, 1'b1, 1'b1, 1'b0, NO_EXP},
            '{REQ_FILL,   32'h0000_0000, 1'b0, 1'b0, 1'b0, NO_EXP},
            '{REQ_FILL,   32'h0000_0000, 1'b1, 1'b1, 1'b0, NO_EXP},
            '{REQ_READ,   32'hAAAA_5555, 1'b0, 1'b0, 1'b0, NO_EXP},
            '{REQ_WRITE,  32'hAAAA_5555, 1'b1, 1'b1, 1'b0, NO_EXP},
            '{REQ_FILL,   32'h5555_AAAA, 1'b1, 1'b0, 1'b0, NO_EXP},
            '{REQ_READ,   32'hAAAA_5555, 1'b0, 1'b1, 1'b0, NO_EXP},
            '{REQ_UNUSED, 32'h5555_AAAA, 1'b0, 1'b0, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{REQ_READ,   32'h8000_0000, 1'b0, 1'b0, 1'b0, NO_EXP},
            '{REQ_WRITE,  32'h8000_0000, 1'b1, 1'b0, 1'b0, NO_EXP},
            '{REQ_FILL,   32'h8000_0000, 1'b1, 1'b1, 1'b0, NO_EXP},
            '{REQ_READ,   32'h8000_0000, 1'b0, 1'b1, 1'b0, NO_EXP},
            '{REQ_WRITE,  32'h0000_0001, 1'b0, 1'b0, 1'b0, NO_EXP},
            '{REQ_READ,   32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, NO_EXP},
            '{REQ_FILL,   32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, NO_EXP},
            '{REQ_READ,   32'h0000_0000, 1'b1, 1'b0, 1'b0, NO_EXP},
            '{REQ_WRITE,  32'h1234_5678, 1'b1, 1'b1, 1'b0, NO_EXP}
        };

        // shadow state after reset
        for (int i = 0; i < ENTRIES; i++)
            shadow_vld[i] = 1'b0;
        shadow_hand  = 0;
        miss_pending = 1'b0;
        miss_slot    = 0;
        miss_addr    = '0;

        // address pool a bit larger than the cache, so hits and evictions mix
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        addr_pool[2] = 32'h8000_0000;
        addr_pool[3] = 32'h0000_0001;
        for (int i = 4; i < POOL_SIZE; i++)
            addr_pool[i] = (i % 3 == 0) ? (addr_pool[i - 1] ^ (32'h1 << $urandom_range(0, 31)))
                                        : $urandom;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < NUM_DIR; k++)
            send_req(dir_tab[k].kind, dir_tab[k].addr, dir_tab[k].ok, dir_tab[k].last,
                     dir_tab[k].typed, dir_tab[k].exp);
        wait_drained();

        // random traffic: mostly lookups on the pool, fills following read misses
        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 3 || n == 2 * RAND_ITEMS / 3)
                wait_drained();
            else if (burst_left == 0) begin
                idle_for($urandom_range(0, 8));
                burst_left = $urandom_range(1, 12);
            end
            pick = $urandom_range(0, 99);
            addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            ok   = $urandom_range(0, 1);
            if (miss_pending && pick < 55) begin
                kind = REQ_FILL;
                ok   = ($urandom_range(0, 99) < 85);
                addr = $urandom;
            end
            else begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    kind = REQ_READ;
                else if (pick < 75)
                    kind = REQ_WRITE;
                else if (pick < 85) begin
                    kind = (pick < 80) ? REQ_READ : REQ_WRITE;
                    addr = $urandom;
                end
                else if (pick < 93)
                    kind = REQ_FILL;
                else begin
                    kind = REQ_UNUSED;
                    addr = $urandom;
                end
            end
            send_req(kind, addr, ok, $urandom_range(0, 1), 1'b0, NO_EXP);
            burst_left--;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d requests: %0d hits, %0d read misses, %0d write misses, %0d unused",
                 req_accepts, n_hits, n_fetches, n_write_miss, n_unused);
        $display("fill reports: %0d applied, %0d dropped, %0d stray; %0d mismatches",
                 n_applied, n_dropped, n_stray, err_count);
        if (err_count == 0)
            $display("** sector_cache_tag_policy_core: PASSED **");
        else
            $display("** sector_cache_tag_policy_core: FAILED **");
        $finish;
    end

endmodule
